// ----- rtl/char_lcd_write_formatter_defines.svh -----
// Assertion macros shared by the character-LCD write formatter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef CHAR_LCD_WRITE_FORMATTER_DEFINES_SVH
`define CHAR_LCD_WRITE_FORMATTER_DEFINES_SVH

// Property checked at every rising edge, off while reset is asserted.
`define LCDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define LCDF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `LCDF_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- rtl/lcdf_pkg.sv -----
// Package for the character-LCD write formatter: payload and control types,
// request codes and LCD constants. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lcdf_pkg;

    // request codes
    localparam logic [2:0] CMD_DATA = 3'd0;
    localparam logic [2:0] CMD_CTRL = 3'd1;
    localparam logic [2:0] CMD_INIT = 3'd2;
    localparam logic [2:0] CMD_NUM  = 3'd3;
    localparam logic [2:0] CMD_POS  = 3'd4;

    localparam int MAG_W       = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int CONV_STEPS  = MAG_W;
    localparam int CNT_W       = $clog2(CONV_STEPS);
    localparam int DIG_W       = $clog2(NUM_DIGITS + 1);
    localparam int INIT_LEN    = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] ROW0_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'hC0;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [7:0]        byte_value;
        logic signed [31:0] number;
        logic [1:0]        row;
        logic [5:0]        col;
    } t_req;

    typedef struct packed {
        logic       is_data;
        logic [7:0] write_byte;
        logic       last;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic conv;
        logic skip;
        logic emit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_is_num;
        logic in_has_out;
        logic conv_last;
        logic skip_more;
        logic emit_last;
    } t_dp_status;

    // function set, display on, clear, entry mode
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h38;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h01;
            default: b = 8'h06;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/char_lcd_write_formatter.sv -----
// Top level of the character-LCD write formatter: controller plus datapath.
// Depends on lcdf_pkg, lcdf_ctrl, lcdf_dp.
//
// channel   direction  handshake          payload
// request   in         i_start & !o_busy  i_req    (t_req)
// write     out        o_strobe, 1 cycle  o_result (t_result)
//
// Data and command requests: accept cycle, then a single write. Cursor requests
// write once for rows 0 and 1, never for rows 2 and 3. Init: four writes on consecutive cycles after the accept cycle.
// Number: shift-add-3 conversion of all 32 magnitude bits, up to 9 leading-zero
// strips and one more check step, then one write per cycle (up to 11, the minus
// sign included); busy from the accept until the last write is issued.
// Each write appears in the cycle after its emit step, from the output register.
// Reset is synchronous active low and returns to idle with no strobe pending.
// Writes cannot be stalled; busy stays high until the last write is issued.
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_write_formatter_defines.svh"

module char_lcd_write_formatter (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  lcdf_pkg::t_req     i_req,
    output logic               o_busy,
    output logic               o_strobe,
    output lcdf_pkg::t_result  o_result
);
    import lcdf_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    lcdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (dp_status),
        .o_dp_cmd (dp_cmd),
        .o_busy   (o_busy)
    );

    lcdf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_dp_cmd (dp_cmd),
        .o_status (dp_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // a new item never yields a write in the cycle right after it is taken
    `LCDF_ASSERT(a_gap_after_accept, i_clk, i_rst_n, (i_start && !o_busy) |=> !o_strobe, "write strobed right after accept")
    `LCDF_ASSERT(a_gap_after_last, i_clk, i_rst_n, (o_strobe && o_result.last) |=> !o_strobe, "write strobed right after last of a run")

endmodule

`default_nettype wire

// ----- rtl/lcdf_ctrl.sv -----
// Sequencer of the LCD write formatter: converts, strips leading zeros, emits.
// Depends on lcdf_pkg; drives lcdf_dp through t_dp_cmd / t_dp_status.
`timescale 1ns / 1ps
`default_nettype none

module lcdf_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  lcdf_pkg::t_dp_status i_status,
    output lcdf_pkg::t_dp_cmd    o_dp_cmd,
    output logic                 o_busy
);
    import lcdf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.load = 1'b1;
                    if (i_status.in_is_num) begin
                        n_state = S_CONV;
                    end else if (i_status.in_has_out) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CONV: begin
                o_dp_cmd.conv = 1'b1;
                if (i_status.conv_last) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_status.skip_more) begin
                    o_dp_cmd.skip = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_dp_cmd.emit = 1'b1;
                if (i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/lcdf_dp.sv -----
// Datapath of the LCD write formatter: request latch, shift-add-3 binary to
// BCD converter, digit shifter and registered result. Depends on lcdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_write_formatter_defines.svh"

module lcdf_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lcdf_pkg::t_req       i_req,
    input  lcdf_pkg::t_dp_cmd    i_dp_cmd,
    output lcdf_pkg::t_dp_status o_status,
    output logic                 o_strobe,
    output lcdf_pkg::t_result    o_result
);
    import lcdf_pkg::*;

    logic [2:0]       r_cmd;
    logic [7:0]       r_byte;
    logic [1:0]       r_row;
    logic [5:0]       r_col;
    logic             r_neg;
    logic [MAG_W-1:0] r_mag;
    logic [BCD_W-1:0] r_bcd;
    logic [CNT_W-1:0] r_cnt;
    logic [DIG_W-1:0] r_dig_left;
    logic             r_out_valid;
    t_result          r_out;

    logic [BCD_W-1:0] adj_bcd;
    logic [MAG_W-1:0] in_mag;
    t_result          n_out;
    logic             top_zero;
    logic             emit_last;

    assign top_zero = (r_bcd[BCD_W-1 -: 4] == 4'd0);

    // status for the controller
    always_comb begin
        o_status.in_is_num  = (i_req.cmd == CMD_NUM);
        o_status.in_has_out = (i_req.cmd inside {CMD_DATA, CMD_CTRL, CMD_INIT})
                            || (i_req.cmd == CMD_POS && !i_req.row[1]);
        o_status.conv_last  = (r_cnt == CNT_W'(CONV_STEPS - 1));
        o_status.skip_more  = top_zero && (r_dig_left > DIG_W'(1));
        o_status.emit_last  = emit_last;
    end

    assign in_mag = i_req.number[31] ? (MAG_W'(0) - MAG_W'(i_req.number))
                                     : MAG_W'(i_req.number);

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            adj_bcd[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_out = '0;
        emit_last = 1'b1;
        case (r_cmd)
            CMD_DATA: begin
                n_out.is_data    = 1'b1;
                n_out.write_byte = r_byte;
            end
            CMD_CTRL: begin
                n_out.write_byte = r_byte;
            end
            CMD_INIT: begin
                n_out.write_byte = init_byte(r_cnt[1:0]);
                emit_last        = (r_cnt[1:0] == 2'(INIT_LEN - 1));
            end
            CMD_NUM: begin
                n_out.is_data = 1'b1;
                if (r_neg) begin
                    n_out.write_byte = CHAR_MINUS;
                    emit_last        = 1'b0;
                end else begin
                    n_out.write_byte = CHAR_ZERO | {4'd0, r_bcd[BCD_W-1 -: 4]};
                    emit_last        = (r_dig_left == DIG_W'(1));
                end
            end
            CMD_POS: begin
                n_out.write_byte = (r_row[0] ? ROW1_BASE : ROW0_BASE) + {2'd0, r_col};
            end
            default: begin
                n_out = '0;
            end
        endcase
        n_out.last = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd      <= i_req.cmd;
            r_byte     <= i_req.byte_value;
            r_row      <= i_req.row;
            r_col      <= i_req.col;
            r_neg      <= i_req.number[31];
            r_mag      <= in_mag;
            r_bcd      <= '0;
            r_cnt      <= '0;
            r_dig_left <= DIG_W'(NUM_DIGITS);
        end else if (i_dp_cmd.conv) begin
            r_bcd <= {adj_bcd[BCD_W-2:0], r_mag[MAG_W-1]};
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_dp_cmd.skip) begin
            r_bcd      <= {r_bcd[BCD_W-5:0], 4'd0};
            r_dig_left <= r_dig_left - DIG_W'(1);
        end else if (i_dp_cmd.emit) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cmd == CMD_NUM) begin
                if (r_neg) begin
                    r_neg <= 1'b0;
                end else begin
                    r_bcd      <= {r_bcd[BCD_W-5:0], 4'd0};
                    r_dig_left <= r_dig_left - DIG_W'(1);
                end
            end
        end
        if (i_dp_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_dp_cmd.emit;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    `LCDF_ASSERT(a_digit_left, i_clk, i_rst_n, (i_dp_cmd.emit && r_cmd == CMD_NUM && !r_neg) |-> (r_dig_left != '0), "digit emitted with no digits left")
    `LCDF_ASSERT(a_skip_keeps_one, i_clk, i_rst_n, i_dp_cmd.skip |-> (top_zero && r_dig_left > DIG_W'(1)), "leading-zero strip would drop the last digit")
    `LCDF_ASSERT_NEVER(a_one_cmd, i_clk, i_rst_n, !$onehot0(i_dp_cmd), "more than one datapath command at once")

endmodule

`default_nettype wire

// ----- tb/char_lcd_write_formatter_test.sv -----
// Self-checking testbench for char_lcd_write_formatter: directed and random requests,
// every LCD write predicted in order and compared field by field.
// Depends on lcdf_pkg and the char_lcd_write_formatter RTL.
`timescale 1ns / 1ps

module char_lcd_write_formatter_test;
    import lcdf_pkg::*;

    // codes the block decodes to "no write"
    localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
    // function set, display on, clear, entry mode; first byte in the top lane
    localparam logic [31:0] LCD_INIT_SEQ = 32'h380C_0106;
    localparam int          DRAIN_CYCLES = 80;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_req    i_req   = '0;
    logic    o_busy;
    logic    o_strobe;
    t_result o_result;

    t_req    req_queue[$];
    t_result pending_writes[$];
    int      n_errors   = 0;
    int      n_accepted = 0;
    int      n_numbers  = 0;
    int      n_writes   = 0;

    char_lcd_write_formatter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Expected run of writes for one accepted request.
    function automatic void predict_writes(input t_req r);
        logic       dat [0:10];
        logic [7:0] byt [0:10];
        logic [7:0] digs [0:9];
        logic [31:0] mag;
        int         n;
        int         cnt;
        int         i;
        t_result    w;
        n   = 0;
        cnt = 0;
        case (r.cmd)
            CMD_DATA: begin
                dat[0] = 1'b1; byt[0] = r.byte_value; n = 1;
            end
            CMD_CTRL: begin
                dat[0] = 1'b0; byt[0] = r.byte_value; n = 1;
            end
            CMD_INIT: begin
                for (i = 0; i < 4; i++) begin
                    dat[i] = 1'b0;
                    byt[i] = LCD_INIT_SEQ[31 - 8 * i -: 8];
                end
                n = 4;
            end
            CMD_NUM: begin
                // unsigned negate covers the most negative value
                mag = r.number[31] ? (~r.number + 32'd1) : r.number;
                do begin
                    digs[cnt] = CHAR_ZERO + 8'(mag % 32'd10);
                    cnt++;
                    mag = mag / 32'd10;
                end while (mag != 0 && cnt < 10);
                if (r.number[31]) begin
                    dat[n] = 1'b1; byt[n] = CHAR_MINUS; n++;
                end
                while (cnt > 0) begin
                    cnt--;
                    dat[n] = 1'b1; byt[n] = digs[cnt]; n++;
                end
            end
            CMD_POS: begin
                if (r.row == 2'd0) begin
                    dat[0] = 1'b0; byt[0] = ROW0_BASE + {2'b00, r.col}; n = 1;
                end else if (r.row == 2'd1) begin
                    dat[0] = 1'b0; byt[0] = ROW1_BASE + {2'b00, r.col}; n = 1;
                end
            end
            default: n = 0;
        endcase
        for (i = 0; i < n; i++) begin
            w.is_data    = dat[i];
            w.write_byte = byt[i];
            w.last       = (i == n - 1);
            pending_writes.push_back(w);
        end
    endfunction

    task automatic queue_req(input logic [2:0] c, input logic [7:0] b,
                             input logic [31:0] num, input logic [1:0] r,
                             input logic [5:0] col);
        t_req q;
        q.cmd        = c;
        q.byte_value = b;
        q.number     = num;
        q.row        = r;
        q.col        = col;
        req_queue.push_back(q);
    endtask

    // Signed value with a random digit count so every output length shows up.
    function automatic logic [31:0] random_number();
        longint lim;
        longint v;
        int     k;
        int     i;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        k   = $urandom_range(1, 10);
        lim = 1;
        for (i = 0; i < k; i++)
            lim = lim * 10;
        v = ({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % lim;
        if (v > 64'd2147483647)
            v = 64'd2147483647;
        if ($urandom_range(0, 1))
            v = -v;
        return v[31:0];
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Driver: holds an item until accepted, idles now and then between items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                predict_writes(i_req);
                n_accepted++;
                if (i_req.cmd == CMD_NUM)
                    n_numbers++;
            end
            if (i_start && o_busy) begin
                // still waiting for the block, keep the item up
            end else if (req_queue.size() > 0 &&
                         !(($urandom_range(0, 99) < 27) &&
                           !(n_accepted >= 80 && n_accepted < 130))) begin
                i_req   <= req_queue.pop_front();
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe is one write, compared with the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_writes.size() == 0) begin
                $display("%0t ns: unexpected write, got is_data=%0b byte=%0h last=%0b",
                         $time, o_result.is_data, o_result.write_byte, o_result.last);
                n_errors++;
            end else begin
                want = pending_writes.pop_front();
                check_field("is_data", 8'(want.is_data), 8'(o_result.is_data));
                check_field("write_byte", want.write_byte, o_result.write_byte);
                check_field("last", 8'(want.last), 8'(o_result.last));
                n_writes++;
            end
        end
    end

    initial begin
        int i;
        int kind;
        // directed: byte extremes, init, number corners, cursor rows, unused codes
        queue_req(CMD_DATA, 8'h00, $urandom, 2'($urandom), 6'($urandom));
        queue_req(CMD_DATA, 8'hFF, $urandom, 2'($urandom), 6'($urandom));
        queue_req(CMD_CTRL, 8'h00, $urandom, 2'($urandom), 6'($urandom));
        queue_req(CMD_CTRL, 8'hFF, $urandom, 2'($urandom), 6'($urandom));
        queue_req(CMD_INIT, 8'($urandom), $urandom, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), 32'd0, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), 32'hFFFF_FFFF, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), 32'd1, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), 32'h7FFF_FFFF, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), 32'h8000_0000, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), 32'd10, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), -32'sd10, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), 32'd1000000000, 2'($urandom), 6'($urandom));
        queue_req(CMD_NUM, 8'($urandom), 32'd999999999, 2'($urandom), 6'($urandom));
        queue_req(CMD_POS, 8'($urandom), $urandom, 2'd0, 6'd0);
        queue_req(CMD_POS, 8'($urandom), $urandom, 2'd0, 6'd39);
        queue_req(CMD_POS, 8'($urandom), $urandom, 2'd1, 6'd0);
        queue_req(CMD_POS, 8'($urandom), $urandom, 2'd1, 6'd63);
        queue_req(CMD_POS, 8'($urandom), $urandom, 2'd2, 6'd5);
        queue_req(CMD_POS, 8'($urandom), $urandom, 2'd3, 6'd63);
        queue_req(CMD_UNUSED_LO, 8'($urandom), $urandom, 2'($urandom), 6'($urandom));
        queue_req(CMD_UNUSED_MID, 8'($urandom), $urandom, 2'($urandom), 6'($urandom));
        queue_req(CMD_UNUSED_HI, 8'($urandom), $urandom, 2'($urandom), 6'($urandom));
        queue_req(CMD_INIT, 8'($urandom), $urandom, 2'($urandom), 6'($urandom));

        for (i = 0; i < 156; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 14)
                queue_req(CMD_DATA, 8'($urandom), $urandom, 2'($urandom), 6'($urandom));
            else if (kind < 26)
                queue_req(CMD_CTRL, 8'($urandom), $urandom, 2'($urandom), 6'($urandom));
            else if (kind < 34)
                queue_req(CMD_INIT, 8'($urandom), $urandom, 2'($urandom), 6'($urandom));
            else if (kind < 64)
                queue_req(CMD_NUM, 8'($urandom), random_number(), 2'($urandom),
                          6'($urandom));
            else if (kind < 92)
                queue_req(CMD_POS, 8'($urandom), $urandom,
                          ($urandom_range(0, 4) == 0) ? 2'($urandom_range(2, 3))
                                                      : 2'($urandom_range(0, 1)),
                          ($urandom_range(0, 5) == 0) ? 6'($urandom_range(40, 63))
                                                      : 6'($urandom_range(0, 39)));
            else
                queue_req(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                          8'($urandom), $urandom, 2'($urandom), 6'($urandom));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_queue.size() > 0 || i_start)
            @(posedge i_clk);
        while (pending_writes.size() > 0)
            @(posedge i_clk);
        // a trailing request may produce no write; drain so that any stray write is still caught
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_writes.size() != 0) begin
            $display("%0t ns: %0d expected writes never arrived", $time,
                     pending_writes.size());
            n_errors++;
        end

        $display("Ran %0d requests (%0d numbers printed), checked %0d LCD writes.",
                 n_accepted, n_numbers, n_writes);
        $display("Errors: %0d", n_errors);
        if (n_errors == 0)
            $display("char_lcd_write_formatter: match");
        else
            $display("char_lcd_write_formatter: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d requests and %0d writes still outstanding.",
                 req_queue.size(), pending_writes.size());
        $display("char_lcd_write_formatter: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lcdf_pkg.sv
rtl/lcdf_ctrl.sv
rtl/lcdf_dp.sv
rtl/char_lcd_write_formatter.sv
tb/char_lcd_write_formatter_test.sv
